// ===== rtl/range_count_at_least_blocked_macros.svh =====
// Assertion helpers for the range count block.
`ifndef RANGE_COUNT_AT_LEAST_BLOCKED_MACROS_SVH
`define RANGE_COUNT_AT_LEAST_BLOCKED_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define RCAL_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define RCAL_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define RCAL_ASSERT_IMP(label, clk, rst_n, a, b)
`define RCAL_ASSERT_NXT(label, clk, rst_n, a, b)
`endif

`endif

// ===== rtl/rcal_pkg.sv =====
`default_nettype none
package rcal_pkg;

  localparam int POS_W = 10;
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;

  // command codes on in_cmd
  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // micro-operations issued by the controller
  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLR,
    OP_LOAD,
    OP_DIV1,
    OP_DIV2,
    OP_U_RDOLD,
    OP_U_GETOLD,
    OP_P1_RD,
    OP_P1_EV,
    OP_P2_INIT,
    OP_P2_PUT,
    OP_P2_RD,
    OP_P2_EV,
    OP_Q_INIT,
    OP_Q_RD,
    OP_Q_EV,
    OP_BS_INIT,
    OP_BS_RD,
    OP_BS_EV,
    OP_BS_ADD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_update;
    logic pos_ok;
    logic p1_last;
    logic p2_at_start;
    logic p2_gt;
    logic q_past;
    logic q_whole;
    logic bs_open;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/rcal_ram.sv =====
`default_nettype none
module rcal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/rcal_ctrl.sv =====
`default_nettype none
module rcal_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire rcal_pkg::dp_stat_t stat,
  output rcal_pkg::ctrl_cmd_t     cmd,
  output logic                    busy,
  output logic                    out_valid
);
  import rcal_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DIV1, ST_DIV2, ST_DISPATCH,
    ST_U_RDOLD, ST_U_GETOLD, ST_P1_RD, ST_P1_EV,
    ST_P2_INIT, ST_P2_CHK, ST_P2_PUT, ST_P2_RD, ST_P2_EV,
    ST_Q_INIT, ST_Q_CHK, ST_Q_RD, ST_Q_EV,
    ST_BS_INIT, ST_BS_CHK, ST_BS_RD, ST_BS_EV, ST_BS_ADD, ST_Q_DONE
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // state register and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR:    if (stat.clr_last) state_r <= ST_IDLE;
        ST_IDLE:     if (start) state_r <= ST_DIV1;
        ST_DIV1:     state_r <= ST_DIV2;
        ST_DIV2:     state_r <= ST_DISPATCH;
        ST_DISPATCH: begin
          if (!stat.is_update) state_r <= ST_Q_INIT;
          else if (stat.pos_ok) state_r <= ST_U_RDOLD;
          else state_r <= ST_IDLE;
        end
        ST_U_RDOLD:  state_r <= ST_U_GETOLD;
        ST_U_GETOLD: state_r <= ST_P1_RD;
        ST_P1_RD:    state_r <= ST_P1_EV;
        ST_P1_EV:    state_r <= stat.p1_last ? ST_P2_INIT : ST_P1_RD;
        ST_P2_INIT:  state_r <= ST_P2_CHK;
        ST_P2_CHK:   state_r <= stat.p2_at_start ? ST_P2_PUT : ST_P2_RD;
        ST_P2_PUT:   state_r <= ST_IDLE;
        ST_P2_RD:    state_r <= ST_P2_EV;
        ST_P2_EV:    state_r <= stat.p2_gt ? ST_P2_CHK : ST_IDLE;
        ST_Q_INIT:   state_r <= ST_Q_CHK;
        ST_Q_CHK: begin
          if (stat.q_past) state_r <= ST_Q_DONE;
          else if (stat.q_whole) state_r <= ST_BS_INIT;
          else state_r <= ST_Q_RD;
        end
        ST_Q_RD:     state_r <= ST_Q_EV;
        ST_Q_EV:     state_r <= ST_Q_CHK;
        ST_BS_INIT:  state_r <= ST_BS_CHK;
        ST_BS_CHK:   state_r <= stat.bs_open ? ST_BS_RD : ST_BS_ADD;
        ST_BS_RD:    state_r <= ST_BS_EV;
        ST_BS_EV:    state_r <= ST_BS_CHK;
        ST_BS_ADD:   state_r <= ST_Q_CHK;
        ST_Q_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default:     state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath operation for each state
  always_comb begin
    case (state_r)
      ST_CLEAR:    cmd.op = OP_CLR;
      ST_IDLE:     cmd.op = OP_LOAD;
      ST_DIV1:     cmd.op = OP_DIV1;
      ST_DIV2:     cmd.op = OP_DIV2;
      ST_U_RDOLD:  cmd.op = OP_U_RDOLD;
      ST_U_GETOLD: cmd.op = OP_U_GETOLD;
      ST_P1_RD:    cmd.op = OP_P1_RD;
      ST_P1_EV:    cmd.op = OP_P1_EV;
      ST_P2_INIT:  cmd.op = OP_P2_INIT;
      ST_P2_PUT:   cmd.op = OP_P2_PUT;
      ST_P2_RD:    cmd.op = OP_P2_RD;
      ST_P2_EV:    cmd.op = OP_P2_EV;
      ST_Q_INIT:   cmd.op = OP_Q_INIT;
      ST_Q_RD:     cmd.op = OP_Q_RD;
      ST_Q_EV:     cmd.op = OP_Q_EV;
      ST_BS_INIT:  cmd.op = OP_BS_INIT;
      ST_BS_RD:    cmd.op = OP_BS_RD;
      ST_BS_EV:    cmd.op = OP_BS_EV;
      ST_BS_ADD:   cmd.op = OP_BS_ADD;
      default:     cmd.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/rcal_dp.sv =====
`default_nettype none
module rcal_dp #(
  parameter int ENTRIES    = 1024,
  parameter int BLOCK_SIZE = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire rcal_pkg::ctrl_cmd_t               cmd,
  input  wire logic                              in_cmd,
  input  wire logic [rcal_pkg::POS_W-1:0]        in_position,
  input  wire logic signed [rcal_pkg::VAL_W-1:0] in_new_value,
  input  wire logic [rcal_pkg::POS_W-1:0]        in_range_low,
  input  wire logic [rcal_pkg::POS_W-1:0]        in_range_high,
  input  wire logic signed [rcal_pkg::VAL_W-1:0] in_threshold,
  output rcal_pkg::dp_stat_t                     stat,
  output logic [rcal_pkg::CNT_W-1:0]             count
);
  import rcal_pkg::*;

  localparam int AW  = $clog2(ENTRIES);
  localparam int IW0 = $clog2(ENTRIES + BLOCK_SIZE + 1);
  localparam int IW  = (IW0 > POS_W + 1) ? IW0 : POS_W + 1;
  // block index by reciprocal: exact for positions of POS_W bits
  localparam int DIV_SH = 2 * POS_W;
  localparam int MW     = DIV_SH + 1;
  localparam int DIV_M  = (1 << DIV_SH) / BLOCK_SIZE + 1;
  localparam int PW     = POS_W + MW;

  localparam logic [IW-1:0] BS_I   = IW'(BLOCK_SIZE);
  localparam logic [IW-1:0] ENT_I  = IW'(ENTRIES);
  localparam logic [IW-1:0] LAST_I = IW'(ENTRIES - 1);

  logic                    cmd_r;
  logic [IW-1:0]           pos_r, lo_r, qhi_r, base_r, k_r, end_r, off_r;
  logic [IW-1:0]           bs_lo_r, bs_hi_r, mid_r;
  logic signed [VAL_W-1:0] nv_r, thr_r, old_r;
  logic [POS_W-1:0]        q_r;
  logic                    found_r;
  logic [CNT_W-1:0]        total_r;

  logic             val_we, srt_we;
  logic [AW-1:0]    val_waddr, val_raddr, srt_waddr, srt_raddr;
  logic [VAL_W-1:0] val_wdata, srt_wdata, val_rdata, srt_rdata;

  logic [POS_W-1:0] div_src;
  logic [PW-1:0]    div_prod;
  logic [IW-1:0]    base_end, mid_w, hi_ext;
  logic             p2_gt, q_hit, bs_less;

  assign div_src  = cmd_r ? pos_r[POS_W-1:0] : lo_r[POS_W-1:0];
  assign div_prod = PW'(div_src) * PW'(DIV_M);
  assign base_end = ((base_r + BS_I) > ENT_I) ? ENT_I : (base_r + BS_I);
  assign mid_w    = bs_lo_r + ((bs_hi_r - bs_lo_r) >> 1);
  assign hi_ext   = IW'(in_range_high);
  assign p2_gt    = $signed(srt_rdata) > nv_r;
  assign q_hit    = $signed(val_rdata) >= thr_r;
  assign bs_less  = $signed(srt_rdata) < thr_r;

  // status toward the controller
  assign stat.clr_last    = (k_r == LAST_I);
  assign stat.is_update   = (cmd_r == CMD_UPDATE);
  assign stat.pos_ok      = (pos_r < ENT_I);
  assign stat.p1_last     = (k_r == end_r - IW'(1));
  assign stat.p2_at_start = (k_r == base_r);
  assign stat.p2_gt       = p2_gt;
  assign stat.q_past      = (k_r > qhi_r);
  assign stat.q_whole     = (off_r == '0) && ((k_r + BS_I) <= (qhi_r + IW'(1)));
  assign stat.bs_open     = (bs_lo_r < bs_hi_r);
  assign count            = total_r;

  // memory port selection
  always_comb begin
    val_we    = 1'b0;
    val_waddr = k_r[AW-1:0];
    val_wdata = '0;
    val_raddr = k_r[AW-1:0];
    srt_we    = 1'b0;
    srt_waddr = k_r[AW-1:0];
    srt_wdata = '0;
    srt_raddr = k_r[AW-1:0];
    case (cmd.op)
      OP_CLR: begin
        val_we = 1'b1;
        srt_we = 1'b1;
      end
      OP_U_RDOLD:  val_raddr = pos_r[AW-1:0];
      OP_U_GETOLD: begin
        val_we    = 1'b1;
        val_waddr = pos_r[AW-1:0];
        val_wdata = nv_r;
      end
      OP_P1_EV: begin
        srt_we    = found_r;
        srt_waddr = AW'(k_r - IW'(1));
        srt_wdata = srt_rdata;
      end
      OP_P2_PUT: begin
        srt_we    = 1'b1;
        srt_wdata = nv_r;
      end
      OP_P2_RD: srt_raddr = AW'(k_r - IW'(1));
      OP_P2_EV: begin
        srt_we    = 1'b1;
        srt_wdata = p2_gt ? srt_rdata : nv_r;
      end
      OP_BS_RD: srt_raddr = mid_w[AW-1:0];
      default: ;
    endcase
  end

  // clear counter shares k_r, so it alone takes reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else begin
      case (cmd.op)
        OP_CLR:     k_r <= k_r + IW'(1);
        OP_U_RDOLD: k_r <= base_r;
        OP_P1_EV:   k_r <= k_r + IW'(1);
        OP_P2_INIT: k_r <= end_r - IW'(1);
        OP_P2_EV:   if (p2_gt) k_r <= k_r - IW'(1);
        OP_Q_INIT:  k_r <= lo_r;
        OP_Q_EV:    k_r <= k_r + IW'(1);
        OP_BS_ADD:  k_r <= k_r + BS_I;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cmd_r <= in_cmd;
        pos_r <= IW'(in_position);
        nv_r  <= in_new_value;
        lo_r  <= IW'(in_range_low);
        qhi_r <= (hi_ext > LAST_I) ? LAST_I : hi_ext;
        thr_r <= in_threshold;
      end
      OP_DIV1:    q_r    <= div_prod[DIV_SH+POS_W-1:DIV_SH];
      OP_DIV2:    base_r <= IW'(q_r * BLOCK_SIZE);
      OP_U_RDOLD: end_r  <= base_end;
      OP_U_GETOLD: begin
        old_r   <= $signed(val_rdata);
        found_r <= 1'b0;
      end
      OP_P1_EV: if (!found_r && ($signed(srt_rdata) == old_r)) found_r <= 1'b1;
      OP_Q_INIT: begin
        off_r   <= lo_r - base_r;
        total_r <= '0;
      end
      OP_Q_EV: begin
        if (q_hit) total_r <= total_r + CNT_W'(1);
        off_r <= (off_r == BS_I - IW'(1)) ? '0 : off_r + IW'(1);
      end
      OP_BS_INIT: begin
        bs_lo_r <= k_r;
        bs_hi_r <= k_r + BS_I;
      end
      OP_BS_RD: mid_r <= mid_w;
      OP_BS_EV: begin
        if (bs_less) bs_lo_r <= mid_r + IW'(1);
        else bs_hi_r <= mid_r;
      end
      OP_BS_ADD: total_r <= total_r + CNT_W'((k_r + BS_I) - bs_lo_r);
      default: ;
    endcase
  end

  rcal_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  rcal_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_srt_ram (
    .clk   (clk),
    .we    (srt_we),
    .waddr (srt_waddr),
    .wdata (srt_wdata),
    .raddr (srt_raddr),
    .rdata (srt_rdata)
  );

endmodule
`default_nettype wire

// ===== rtl/range_count_at_least_blocked.sv =====
// Range count of entries at least a threshold, over an array kept in blocks.
// Input channel: a command beat is taken when start is high and busy is low.
//   in_cmd = 1 writes in_new_value at in_position and re-sorts that block's
//   sorted copy; in_cmd = 0 counts entries in [in_range_low, in_range_high]
//   whose value is at least in_threshold.
// Result channel: out_valid strobes for one cycle with out_count, once per
//   query and never for an update. The receiver cannot stall; each result
//   beat must be taken in the cycle it appears.
// Busy time: an update holds busy through setup, a removal pass over the
//   entries of its block and an insertion pass; an update past the array
//   goes back to idle after its dispatch step.
//   A query holds busy through setup, a read of each edge entry and, per
//   whole block, a binary search of its sorted copy; its result beat shows
//   in the first cycle with busy low, and the next command can be taken at
//   the end of that first idle cycle. The single read port of each block
//   RAM sets the pace of these passes.
// Reset: both RAMs are cleared by a pass over all ENTRIES entries, one entry
//   per cycle, with busy high; no command is taken until it ends.
`default_nettype none
`include "range_count_at_least_blocked_macros.svh"
module range_count_at_least_blocked #(
  parameter int ENTRIES    = 1024,
  parameter int BLOCK_SIZE = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_cmd,
  input  wire logic [rcal_pkg::POS_W-1:0]        in_position,
  input  wire logic signed [rcal_pkg::VAL_W-1:0] in_new_value,
  input  wire logic [rcal_pkg::POS_W-1:0]        in_range_low,
  input  wire logic [rcal_pkg::POS_W-1:0]        in_range_high,
  input  wire logic signed [rcal_pkg::VAL_W-1:0] in_threshold,
  output logic                                   out_valid,
  output logic [rcal_pkg::CNT_W-1:0]             out_count
);
  import rcal_pkg::*;

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  rcal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  rcal_dp #(.ENTRIES(ENTRIES), .BLOCK_SIZE(BLOCK_SIZE)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (ctl),
    .in_cmd        (in_cmd),
    .in_position   (in_position),
    .in_new_value  (in_new_value),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .in_threshold  (in_threshold),
    .stat          (stat),
    .count         (out_count)
  );

  // a result beat only follows work
  `RCAL_ASSERT_IMP(a_strobe_after_work, clk, rst_n, out_valid, $past(busy))
  // an accepted update never strobes a result
  `RCAL_ASSERT_NXT(a_update_silent, clk, rst_n, start && !busy && in_cmd, !out_valid)
  // one strobe per query
  `RCAL_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  // the block is idle while a result beat is shown
  `RCAL_ASSERT_IMP(a_idle_on_result, clk, rst_n, out_valid, !busy)

endmodule
`default_nettype wire

// ===== bench/range_count_checker.sv =====
`timescale 1ns / 1ps
// Watches the command and result channels, predicts each count and compares.
module range_count_checker #(
  parameter int ENTRIES    = 1024,
  parameter int BLOCK_SIZE = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic                                   in_cmd,
  input  logic [rcal_pkg::POS_W-1:0]             in_position,
  input  logic signed [rcal_pkg::VAL_W-1:0]      in_new_value,
  input  logic [rcal_pkg::POS_W-1:0]             in_range_low,
  input  logic [rcal_pkg::POS_W-1:0]             in_range_high,
  input  logic signed [rcal_pkg::VAL_W-1:0]      in_threshold,
  input  logic                                   out_valid,
  input  logic [rcal_pkg::CNT_W-1:0]             out_count,
  output int                                     fail_count,
  output int                                     pending_counts
);
  import rcal_pkg::*;

  localparam int FIFO_DEPTH = 64;

  // shadow of the array and of each block's sorted copy
  logic signed [31:0] shadow_vals [ENTRIES];
  logic signed [31:0] shadow_sorted [ENTRIES];

  // expected counts in order, as a ring of slots
  logic [CNT_W-1:0] count_fifo [FIFO_DEPTH];
  int fifo_wr = 0;
  int fifo_rd = 0;

  assign pending_counts = fifo_wr - fifo_rd;

  // insertion sort of one block's copy
  function automatic void resort(int first);
    int last;
    int j;
    logic signed [31:0] v;
    last = (first + BLOCK_SIZE > ENTRIES) ? ENTRIES : first + BLOCK_SIZE;
    for (int i = first; i < last; i++) begin
      v = shadow_vals[i];
      j = i;
      while (j > first && shadow_sorted[j-1] > v) begin
        shadow_sorted[j] = shadow_sorted[j-1];
        j--;
      end
      shadow_sorted[j] = v;
    end
  endfunction

  // entries >= thr in sorted [first, last)
  function automatic int count_sorted(int first, int last, logic signed [31:0] thr);
    int lo;
    int hi;
    int mid;
    lo = first;
    hi = last;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_sorted[mid] < thr) lo = mid + 1;
      else hi = mid;
    end
    return last - lo;
  endfunction

  function automatic int predict_count(int lo, int hi, logic signed [31:0] thr);
    int total;
    int i;
    total = 0;
    if (hi > ENTRIES - 1) hi = ENTRIES - 1;
    if (lo < ENTRIES && lo <= hi) begin
      i = lo;
      while (i <= hi) begin
        if (i % BLOCK_SIZE == 0 && i + BLOCK_SIZE <= hi + 1) begin
          total += count_sorted(i, i + BLOCK_SIZE, thr);
          i += BLOCK_SIZE;
        end else begin
          if (shadow_vals[i] >= thr) total++;
          i++;
        end
      end
    end
    return total;
  endfunction

  // predict on accepted command beats, compare result beats
  always @(posedge clk) begin
    logic [CNT_W-1:0] want;
    int upd_pos;
    if (!rst_n) begin
      for (int k = 0; k < ENTRIES; k++) begin
        shadow_vals[k] = '0;
        shadow_sorted[k] = '0;
      end
      fifo_wr = 0;
      fifo_rd = 0;
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (fifo_wr == fifo_rd) begin
          $display("%0t: unexpected count beat, expected none, actual %0d",
                   $time, out_count);
          fail_count++;
        end else begin
          want = count_fifo[fifo_rd % FIFO_DEPTH];
          fifo_rd++;
          if (out_count !== want) begin
            $display("%0t: count mismatch, expected %0d, actual %0d",
                     $time, want, out_count);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (in_cmd == CMD_QUERY) begin
          count_fifo[fifo_wr % FIFO_DEPTH] = CNT_W'(predict_count(
            int'(in_range_low), int'(in_range_high), in_threshold));
          fifo_wr++;
        end else begin
          upd_pos = int'(in_position);
          if (upd_pos < ENTRIES) begin
            shadow_vals[upd_pos] = in_new_value;
            resort(upd_pos - upd_pos % BLOCK_SIZE);
          end
        end
      end
    end
  end
endmodule

// ===== bench/tb_range_count_at_least_blocked.sv =====
`timescale 1ns / 1ps
module tb_range_count_at_least_blocked;
  import rcal_pkg::*;

  localparam int  ENTRIES    = 1024;
  localparam int  BLOCK_SIZE = 32;
  localparam int  IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = 1'b0;
  logic [POS_W-1:0] in_position = '0;
  logic signed [VAL_W-1:0] in_new_value = '0;
  logic [POS_W-1:0] in_range_low = '0;
  logic [POS_W-1:0] in_range_high = '0;
  logic signed [VAL_W-1:0] in_threshold = '0;
  logic out_valid;
  logic [CNT_W-1:0] out_count;
  int fail_count;
  int pending_counts;
  int idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  range_count_at_least_blocked #(.ENTRIES(ENTRIES), .BLOCK_SIZE(BLOCK_SIZE)) DUT (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_position, .in_new_value,
    .in_range_low, .in_range_high, .in_threshold, .out_valid, .out_count
  );

  range_count_checker #(.ENTRIES(ENTRIES), .BLOCK_SIZE(BLOCK_SIZE)) checker_i (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_position, .in_new_value,
    .in_range_low, .in_range_high, .in_threshold, .out_valid, .out_count,
    .fail_count, .pending_counts
  );

  // watchdog: cycles without any accepted beat
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one command beat, after a random gap, held until taken
  task automatic send_beat(logic cmd, int pos, logic [31:0] nv,
                           int lo, int hi, logic [31:0] thr);
    repeat ($urandom_range(0, 11)) @(negedge clk);
    start <= 1'b1;
    in_cmd <= cmd;
    in_position <= POS_W'(pos);
    in_new_value <= nv;
    in_range_low <= POS_W'(lo);
    in_range_high <= POS_W'(hi);
    in_threshold <= thr;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start <= 1'b0;
    in_cmd <= 1'($urandom_range(0, 1));
    in_position <= POS_W'($urandom);
    in_new_value <= $urandom;
  endtask

  // values biased toward extremes and near collisions with thresholds
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 8) - 4;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int lo;
    int hi;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: queries on the cleared array, extremes, updates, empty ranges
    send_beat(CMD_QUERY, 0, 0, 0, 1023, 32'h0000_0000);
    send_beat(CMD_QUERY, 0, 0, 0, 1023, 32'h0000_0001);
    send_beat(CMD_QUERY, 0, 0, 0, 1023, 32'h8000_0000);
    send_beat(CMD_UPDATE, 0, 32'h8000_0000, 0, 0, 0);
    send_beat(CMD_UPDATE, 1023, 32'h7fff_ffff, 1023, 1023, 32'hffff_ffff);
    send_beat(CMD_UPDATE, 31, 32'hffff_ffff, 0, 0, 0);
    send_beat(CMD_UPDATE, 32, 5, 0, 0, 0);
    send_beat(CMD_QUERY, 1023, 0, 0, 1023, 32'h7fff_ffff);
    send_beat(CMD_QUERY, 0, 0, 0, 1023, 32'h8000_0000);
    send_beat(CMD_QUERY, 0, 0, 0, 0, 32'h8000_0000);
    send_beat(CMD_QUERY, 0, 0, 1023, 1023, 32'h7fff_ffff);
    send_beat(CMD_QUERY, 0, 0, 5, 4, 32'h8000_0000);
    send_beat(CMD_QUERY, 0, 0, 1023, 0, 32'h8000_0000);
    send_beat(CMD_QUERY, 0, 0, 31, 32, 32'hffff_ffff);
    send_beat(CMD_QUERY, 0, 0, 1, 62, 32'h0000_0000);
    send_beat(CMD_QUERY, 0, 0, 32, 63, 32'h0000_0005);
    send_beat(CMD_QUERY, 0, 0, 0, 31, 32'hffff_ffff);

    // sender holds off until the block has delivered every count
    wait (pending_counts == 0);

    // random: updates, mostly to a few blocks, and queries mostly over them
    for (int n = 0; n < 1550; n++) begin
      if (n == 800) wait (pending_counts == 0);
      if ($urandom_range(0, 9) < 5) begin
        send_beat(CMD_UPDATE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                  : $urandom_range(0, 127), pick_value(), $urandom, $urandom, $urandom);
      end else begin
        lo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 160);
        hi = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
             : lo + $urandom_range(0, 100);
        if (hi > 1023) hi = 1023;
        send_beat(CMD_QUERY, $urandom, $urandom, lo, hi, pick_value());
      end
    end

    wait (pending_counts == 0);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
